[hdl/ssc_pkg.sv]
`default_nettype none
package ssc_pkg;

    localparam int DEPTH      = 1024;
    localparam int VALUE_BITS = 16;
    localparam int ADDR_BITS  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS   = $clog2(DEPTH + 1);
    localparam int EXP_BITS   = VALUE_BITS + 1;

    typedef struct packed {
        logic [VALUE_BITS-1:0] value;
        logic                  last;
    } t_in;

    typedef struct packed {
        logic sortable;
        logic overflow;
    } t_out;

    // controller -> datapath
    typedef struct packed {
        logic latch;     // capture the input beat
        logic pop;       // drop the top entry, advance the counter, fetch the new top
        logic load_top;  // take the fetched entry as the new top
        logic decide;    // match, fail, overflow or push the held value
        logic emit;      // load the verdict register and clear the sequence state
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic dead;      // sequence already failed or overflowed
        logic pop_hit;   // stack not empty and top equals the expected number
        logic last;      // held beat closes the sequence
    } t_sts;

endpackage
`default_nettype wire

[hdl/ssc_dp.sv]
`default_nettype none
module ssc_dp (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire ssc_pkg::t_in  i_in_data,
    input  wire ssc_pkg::t_cmd i_cmd,
    output ssc_pkg::t_sts      o_sts,
    output ssc_pkg::t_out      o_out_data
);
    import ssc_pkg::*;

    logic [VALUE_BITS-1:0] r_mem [DEPTH];
    logic [VALUE_BITS-1:0] r_rd;
    logic [VALUE_BITS-1:0] r_val, n_val;
    logic [VALUE_BITS-1:0] r_top, n_top;
    logic                  r_last, n_last;
    logic [CNT_BITS-1:0]   r_count, n_count;
    logic [EXP_BITS-1:0]   r_exp, n_exp;
    logic                  r_failed, n_failed;
    logic                  r_ovf, n_ovf;
    t_out                  r_res, n_res;

    logic                  non_empty;
    logic                  full;
    logic                  push;
    logic [CNT_BITS-1:0]   rd_idx;
    logic [EXP_BITS-1:0]   exp_inc;

    assign non_empty = (r_count != '0);
    assign full      = (r_count == CNT_BITS'(DEPTH));
    assign exp_inc   = r_exp + EXP_BITS'(1);
    // new top sits two below the current count after a pop
    assign rd_idx    = r_count - CNT_BITS'(2);

    assign o_sts.dead    = r_failed | r_ovf;
    assign o_sts.pop_hit = non_empty && ({1'b0, r_top} == r_exp);
    assign o_sts.last    = r_last;
    assign o_out_data    = r_res;

    always_comb begin
        n_val    = r_val;
        n_last   = r_last;
        n_top    = r_top;
        n_count  = r_count;
        n_exp    = r_exp;
        n_failed = r_failed;
        n_ovf    = r_ovf;
        n_res    = r_res;
        push     = 1'b0;

        if (i_cmd.latch) begin
            n_val  = i_in_data.value;
            n_last = i_in_data.last;
        end
        if (i_cmd.pop) begin
            n_exp   = exp_inc;
            n_count = r_count - CNT_BITS'(1);
        end
        if (i_cmd.load_top) begin
            n_top = r_rd;
        end
        if (i_cmd.decide) begin
            if ({1'b0, r_val} == r_exp) begin
                n_exp = exp_inc;
            end else if (non_empty && (r_val > r_top)) begin
                n_failed = 1'b1;
            end else if (full) begin
                n_ovf = 1'b1;
            end else begin
                push    = 1'b1;
                n_top   = r_val;
                n_count = r_count + CNT_BITS'(1);
            end
        end
        if (i_cmd.emit) begin
            n_res.sortable = !(r_failed || r_ovf);
            n_res.overflow = r_ovf;
            n_count        = '0;
            n_exp          = EXP_BITS'(1);
            n_failed       = 1'b0;
            n_ovf          = 1'b0;
        end
    end

    // stack storage: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_count[ADDR_BITS-1:0]] <= r_val;
        end
        r_rd <= r_mem[rd_idx[ADDR_BITS-1:0]];
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
        r_top <= n_top;
        r_res <= n_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last   <= 1'b0;
            r_count  <= '0;
            r_exp    <= EXP_BITS'(1);
            r_failed <= 1'b0;
            r_ovf    <= 1'b0;
        end else begin
            r_last   <= n_last;
            r_count  <= n_count;
            r_exp    <= n_exp;
            r_failed <= n_failed;
            r_ovf    <= n_ovf;
        end
    end

endmodule
`default_nettype wire

[hdl/ssc_ctrl.sv]
`default_nettype none
module ssc_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    input  wire ssc_pkg::t_sts i_sts,
    output ssc_pkg::t_cmd      o_cmd
);
    import ssc_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_POP,
        S_LOAD,
        S_DECIDE,
        S_FINISH
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    assign out_free    = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = i_sts.dead ? S_FINISH : S_POP;
                end
            end
            S_POP: begin
                if (i_sts.pop_hit) begin
                    o_cmd.pop = 1'b1;
                    n_state   = S_LOAD;
                end else begin
                    n_state = S_DECIDE;
                end
            end
            S_LOAD: begin
                o_cmd.load_top = 1'b1;
                n_state        = S_POP;
            end
            S_DECIDE: begin
                o_cmd.decide = 1'b1;
                n_state      = S_FINISH;
            end
            S_FINISH: begin
                if (!i_sts.last) begin
                    n_state = S_IDLE;
                end else if (out_free) begin
                    o_cmd.emit  = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule
`default_nettype wire

[hdl/stack_sortable_sequence_check_core.sv]
`default_nettype none
// Channel | Direction | Handshake              | Beat payload
// --------+-----------+------------------------+-----------------------------
// in      | input     | i_in_valid/o_in_ready  | i_in_data  (value, last)
// out     | output    | o_out_valid/i_out_ready| o_out_data (sortable, overflow)
//
// Each item passes through accept, pop check, decide and finish, and each stack
// entry popped ahead of it adds a pop and a top reload; an item of a sequence
// that has already failed goes from accept straight to finish. Each pop is a
// registered-read-port fetch from the stack memory and a top-register reload.
// Reset (i_rst_n low, synchronous) empties the stack count, sets the expected
// number to one and clears the failure flags; the stack memory needs no clear.
// A verdict beat waiting on i_out_ready blocks only the closing step of the
// next sequence; earlier items of that sequence are still taken.
module stack_sortable_sequence_check_core (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire ssc_pkg::t_in  i_in_data,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output ssc_pkg::t_out      o_out_data
);
    import ssc_pkg::*;

    t_cmd cmd;
    t_sts sts;

    // sequencing: one beat at a time through pop / decide / finish
    ssc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // stack memory, top register, expected counter, sticky flags, verdict register
    ssc_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_data  (i_in_data),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .o_out_data (o_out_data)
    );

endmodule
`default_nettype wire

[tb/sv/tb_top.sv]
`default_nettype none
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import ssc_pkg::*;

    // Number of random beats to send after the directed tests.
    localparam int RAND_BEATS = 1250;
    // Hard stop on the cycle counter. The slowest legal run is about 3500 beats,
    // each with its idle gap, core steps and pops, plus the verdict stalls.
    // This limit leaves several times that margin.
    localparam int CYCLE_LIMIT = 500000;
    // Settle time after the last verdict. Only the closing beat of a sequence
    // makes a verdict, so nothing is still in flight by then.
    localparam int DRAIN_CYCLES = 16;
    localparam int MAX_SHOWN = 10;

    logic    i_clk = 1'b0;
    logic    i_rst_n;
    logic    i_in_valid;
    logic    o_in_ready;
    t_in     i_in_data;
    logic    o_out_valid;
    logic    i_out_ready;
    t_out    o_out_data;

    // Expected verdicts, oldest first.
    t_out    verdict_q[$];
    int      err_cnt = 0;
    int      shown_cnt = 0;
    int      cycle_cnt = 0;
    int      beats_sent = 0;
    // Set while a stretch of back-to-back traffic is wanted on both channels.
    bit      no_idle = 1'b0;

    // Shadow state of the sorting stack.
    logic [VALUE_BITS-1:0] stk_mem [DEPTH];
    int                    stk_cnt = 0;
    logic [EXP_BITS-1:0]   exp_num = 1;
    bit                    seq_failed = 1'b0;
    bit                    seq_ovf = 1'b0;

    stack_sortable_sequence_check_core DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data)
    );

    always #2 i_clk = ~i_clk;

    // Watchdog: a hung handshake ends the run here.
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Idle cycles before a beat on either channel.
    function automatic int draw_wait();
        if (no_idle) begin
            return 0;
        end
        return $urandom_range(0, 12);
    endfunction

    // Advance the shadow stack by one beat. Return 1 and the verdict when the
    // beat closes its sequence, 0 otherwise.
    function automatic bit predict_verdict(input t_in b, output t_out v);
        logic [EXP_BITS-1:0] val;
        val = {1'b0, b.value};
        v   = '0;
        // A failed or overflowed sequence ignores everything up to its last beat.
        if (!seq_failed && !seq_ovf) begin
            // Drain stack tops that are next in line.
            while (stk_cnt > 0 && {1'b0, stk_mem[stk_cnt-1]} == exp_num) begin
                exp_num++;
                stk_cnt--;
            end
            if (val == exp_num) begin
                exp_num++;
            end else if (stk_cnt > 0 && val > {1'b0, stk_mem[stk_cnt-1]}) begin
                // Burying a smaller value under a larger one can never be undone.
                seq_failed = 1'b1;
            end else if (stk_cnt >= DEPTH) begin
                // Full stack: drop the value and poison the sequence.
                seq_ovf = 1'b1;
            end else begin
                stk_mem[stk_cnt] = b.value;
                stk_cnt++;
            end
        end
        if (!b.last) begin
            return 1'b0;
        end
        v.sortable = !seq_failed && !seq_ovf;
        v.overflow = seq_ovf;
        stk_cnt    = 0;
        exp_num    = 1;
        seq_failed = 1'b0;
        seq_ovf    = 1'b0;
        return 1'b1;
    endfunction

    // Send one beat. Called in the time step of the previous acceptance (or of
    // reset release); returns in the time step where this beat is accepted.
    task automatic send_beat(input int val, input bit is_last);
        int   gap;
        t_in  b;
        t_out v;
        gap     = draw_wait();
        b.value = val[VALUE_BITS-1:0];
        b.last  = is_last;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= b;
        // Hold valid and payload until the core takes the beat.
        do @(posedge i_clk); while (!o_in_ready);
        if (predict_verdict(b, v)) begin
            verdict_q.push_back(v);
        end
        beats_sent++;
    endtask

    // Send a whole sequence, marking the final value as last.
    task automatic send_seq(input int vals[$]);
        foreach (vals[k]) begin
            send_beat(vals[k], k == vals.size() - 1);
        end
    endtask

    // Verdict channel: stall ready at random, and check every beat taken
    // against the oldest prediction.
    int stall_left = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            stall_left = draw_wait();
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (verdict_q.size() == 0) begin
                    err_cnt++;
                    if (shown_cnt < MAX_SHOWN) begin
                        shown_cnt++;
                        $display("unexpected verdict: sortable %0b overflow %0b",
                                 o_out_data.sortable, o_out_data.overflow);
                    end
                end else begin
                    t_out exp_v;
                    exp_v = verdict_q.pop_front();
                    if (o_out_data.sortable !== exp_v.sortable ||
                        o_out_data.overflow !== exp_v.overflow) begin
                        err_cnt++;
                        if (shown_cnt < MAX_SHOWN) begin
                            shown_cnt++;
                            $display("verdict mismatch: sortable exp %0b got %0b, %s",
                                     exp_v.sortable, o_out_data.sortable,
                                     $sformatf("overflow exp %0b got %0b",
                                               exp_v.overflow, o_out_data.overflow));
                        end
                    end
                end
                stall_left = draw_wait();
            end
            if (stall_left > 0) begin
                stall_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // Lone closing beats: the first number, zero, the largest value and two.
    task automatic test_single_beats();
        send_seq('{1});
        send_seq('{0});
        send_seq('{65535});
        send_seq('{2});
    endtask

    // Short orders: ascending, descending, a buried smaller value (fails),
    // values after a failure, duplicates and zeros, top-of-range values.
    task automatic test_short_orders();
        send_seq('{1, 2, 3});
        send_seq('{3, 2, 1});
        send_seq('{2, 3, 1});
        send_seq('{3, 1, 2});
        send_seq('{2, 3, 1, 4});
        send_seq('{2, 2, 1});
        send_seq('{0, 1, 0});
        send_seq('{65535, 65534, 1});
    endtask

    // Fill the stack exactly to DEPTH, then force one pop per entry when the
    // closing value arrives. No overflow.
    task automatic test_full_stack();
        for (int k = DEPTH + 1; k >= 2; k--) begin
            send_beat(k, 1'b0);
        end
        send_beat(1, 1'b0);
        send_beat(DEPTH + 2, 1'b1);
    endtask

    // One push past DEPTH: overflow, later values dropped, verdict forced low.
    task automatic test_overflow();
        for (int k = DEPTH + 2; k >= 2; k--) begin
            send_beat(k, 1'b0);
        end
        send_beat(DEPTH + 5, 1'b0);
        send_beat(1, 1'b1);
        // The sequence after an overflow starts clean.
        send_seq('{1, 2});
    endtask

    // Random sequences. Most are permutations, most of those stack-sortable by
    // construction; the rest are noise over the full value range and short
    // runs with duplicates and zeros.
    task automatic test_random_sequences();
        int vals[$];
        int popped[$];
        int held[$];
        int kind;
        int n;
        int nxt;
        int j;
        int tmp;
        int start;
        start = beats_sent;
        while (beats_sent - start < RAND_BEATS) begin
            kind    = $urandom_range(0, 99);
            n       = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 48)
                                                  : $urandom_range(1, 12);
            no_idle = ($urandom_range(0, 4) == 0);
            vals.delete();
            if (kind < 45) begin
                // Random push/pop schedule on 1..n gives a stack-realizable
                // order; its inverse is a stack-sortable input.
                popped.delete();
                held.delete();
                nxt = 1;
                while (popped.size() < n) begin
                    if (nxt <= n && (held.size() == 0 || $urandom_range(0, 1) == 1)) begin
                        held.push_back(nxt);
                        nxt++;
                    end else begin
                        popped.push_back(held.pop_back());
                    end
                end
                for (int k = 0; k < n; k++) begin
                    vals.push_back(0);
                end
                foreach (popped[k]) begin
                    vals[popped[k] - 1] = k + 1;
                end
            end else if (kind < 70) begin
                for (int k = 1; k <= n; k++) begin
                    vals.push_back(k);
                end
                for (int k = n - 1; k > 0; k--) begin
                    j       = $urandom_range(0, k);
                    tmp     = vals[k];
                    vals[k] = vals[j];
                    vals[j] = tmp;
                end
            end else if (kind < 85) begin
                for (int k = 0; k < n; k++) begin
                    vals.push_back($urandom_range(0, 65535));
                end
            end else begin
                for (int k = 0; k < n; k++) begin
                    vals.push_back($urandom_range(0, n));
                end
            end
            send_seq(vals);
        end
        no_idle = 1'b0;
    endtask

    initial begin
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_data  <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_single_beats();
        test_short_orders();
        test_full_stack();
        test_overflow();
        test_random_sequences();

        // Drop valid, let every expected verdict arrive, then settle.
        i_in_valid <= 1'b0;
        while (verdict_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (err_cnt == 0 && verdict_q.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
`default_nettype wire
